[design/tma_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the moving-average thermostat controller.
// Used by every module of the block; depends on nothing else.
package tma_pkg;

  // Field widths.
  localparam int unsigned TEMP_W   = 9;
  localparam int unsigned ADC_W    = 10;
  localparam int unsigned SUM_W    = 13;
  localparam int unsigned MARGIN_W = 6;
  localparam int unsigned MODE_W   = 2;

  // Register port geometry.
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  // Register values after reset.
  localparam logic [MARGIN_W-1:0] BAND_MARGIN_RST    = 6'd5;
  localparam logic [TEMP_W-1:0]   LOWEST_SETPOINT_RST  = 9'd35;
  localparam logic [TEMP_W-1:0]   HIGHEST_SETPOINT_RST = 9'd75;
  localparam logic [TEMP_W-1:0]   START_SETPOINT_RST   = 9'd60;

  // Configuration registers.
  typedef struct packed {
    logic [MARGIN_W-1:0] band_margin;
    logic [TEMP_W-1:0]   lowest_setpoint;
    logic [TEMP_W-1:0]   highest_setpoint;
    logic [TEMP_W-1:0]   start_setpoint;
  } cfg_t;

  // One input item.
  typedef struct packed {
    logic             power_enable;
    logic             sample_valid;
    logic [ADC_W-1:0] adc_sample;
    logic             btn_up;
    logic             btn_down;
    logic             blink_phase;
    logic             setting_timeout;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              heater_on;
    logic              cooler_on;
    logic              led_on;
    logic              display_on;
    logic [TEMP_W-1:0] display_value;
    logic [TEMP_W-1:0] setpoint_save;
  } out_item_t;

  // Per-item control carried down the pipeline to the decision stage.
  typedef struct packed {
    out_item_t         res;
    logic              decide;
    logic              blink;
    logic [TEMP_W-1:0] setpoint;
  } ctl_t;

  // Window update request for one item.
  typedef struct packed {
    logic              take;
    logic              prime;
    logic              stale;
    logic [TEMP_W-1:0] temp;
  } samp_t;

endpackage

[design/thermostat_moving_average_control.sv]
`timescale 1ns / 1ps
// Thermostat controller with a moving-average temperature window; the top level.
// Depends on tma_pkg, tma_ctrl, tma_window and tma_decide.
//
// The block takes one item per clock cycle unless the receiver stalls it, and
// returns one result item for each, in order: the item is decoded and the window
// memory read in the accept stage, the running sum is updated and the slot
// written back in the next, the average is formed by a reciprocal multiply in
// the third, and the dead-band compare lands in the output register in the
// fourth. The window sits in a small single-port-per-side memory; a fill count
// stands in for clearing it, so there is no clearing pass after reset. Each stage
// holds its item while the next is full, so up to four items can be in flight
// while a result waits to be taken. Registers (band margin, setpoint limits, start
// setpoint) must be written over the APB port only while the block is idle, which
// it does not enforce; a start setpoint write also loads the working setpoint.
module thermostat_moving_average_control #(
  parameter int unsigned WINDOW_LEN = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tma_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tma_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tma_pkg::CFG_AW-1:0]  paddr,
  input  logic [tma_pkg::CFG_DW-1:0]  pwdata,
  output logic [tma_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import tma_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW_LEN);

  typedef enum logic [1:0] {
    REG_BAND_MARGIN      = 2'd0,
    REG_LOWEST_SETPOINT  = 2'd1,
    REG_HIGHEST_SETPOINT = 2'd2,
    REG_START_SETPOINT   = 2'd3
  } cfg_reg_t;

  cfg_t     cfg_r;
  cfg_reg_t cfg_idx;
  logic     cfg_wr, sp_load;

  // Register port.
  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_t'(paddr[CFG_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign sp_load = cfg_wr && (cfg_idx == REG_START_SETPOINT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.band_margin      <= BAND_MARGIN_RST;
      cfg_r.lowest_setpoint  <= LOWEST_SETPOINT_RST;
      cfg_r.highest_setpoint <= HIGHEST_SETPOINT_RST;
      cfg_r.start_setpoint   <= START_SETPOINT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BAND_MARGIN:      cfg_r.band_margin      <= pwdata[MARGIN_W-1:0];
        REG_LOWEST_SETPOINT:  cfg_r.lowest_setpoint  <= pwdata[TEMP_W-1:0];
        REG_HIGHEST_SETPOINT: cfg_r.highest_setpoint <= pwdata[TEMP_W-1:0];
        REG_START_SETPOINT:   cfg_r.start_setpoint   <= pwdata[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BAND_MARGIN:      prdata = CFG_DW'(cfg_r.band_margin);
      REG_LOWEST_SETPOINT:  prdata = CFG_DW'(cfg_r.lowest_setpoint);
      REG_HIGHEST_SETPOINT: prdata = CFG_DW'(cfg_r.highest_setpoint);
      REG_START_SETPOINT:   prdata = CFG_DW'(cfg_r.start_setpoint);
      default:              prdata = '0;
    endcase
  end

  // Pipeline occupancy: each stage moves on when the one after it can take it.
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic rdy_out, rdy3, rdy2, rdy1;
  logic acc, mv1, mv2, mv3;

  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy3     = !v3_r || rdy_out;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign acc      = in_valid && rdy1;
  assign mv1      = v1_r && rdy2;
  assign mv2      = v2_r && rdy3;
  assign mv3      = v3_r && rdy_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= acc || (v1_r && !mv1);
      v2_r        <= mv1 || (v2_r && !mv2);
      v3_r        <= mv2 || (v3_r && !mv3);
      out_valid_r <= mv3 || (out_valid_r && out_stall);
    end
  end

  // Front stage.
  ctl_t              ctl0, ctl1_r, ctl2_r;
  samp_t             samp0, samp1_r;
  logic [SLOT_W-1:0] slot0, slot1_r;
  logic [SUM_W-1:0]  sum;

  tma_ctrl #(.WINDOW_LEN(WINDOW_LEN)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (acc),
    .item          (in_data),
    .cfg           (cfg_r),
    .sp_load       (sp_load),
    .sp_load_value (pwdata[TEMP_W-1:0]),
    .ctl           (ctl0),
    .samp          (samp0),
    .slot          (slot0)
  );

  // Item control registers between stages.
  always_ff @(posedge clk) begin
    if (acc) begin
      ctl1_r  <= ctl0;
      samp1_r <= samp0;
      slot1_r <= slot0;
    end
    if (mv1) begin
      ctl2_r <= ctl1_r;
    end
  end

  tma_window #(.WINDOW_LEN(WINDOW_LEN)) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (acc),
    .rd_slot (slot0),
    .wr_en   (mv1),
    .wr_slot (slot1_r),
    .samp    (samp1_r),
    .sum     (sum)
  );

  tma_decide #(.WINDOW_LEN(WINDOW_LEN)) u_decide (
    .clk         (clk),
    .ld_avg      (mv2),
    .ld_out      (mv3),
    .sum         (sum),
    .ctl         (ctl2_r),
    .band_margin (cfg_r.band_margin),
    .out_data    (out_data)
  );

  assign out_valid = out_valid_r;

`ifndef SYNTH
  // Input is held off only when every stage, output included, is occupied.
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && v3_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

  // Heating and cooling are never driven together.
  a_no_heat_and_cool: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data.heater_on && out_data.cooler_on))
    else $error("heater and cooler driven at once");
`endif

endmodule

[design/tma_ctrl.sv]
`timescale 1ns / 1ps
// Front stage: mode sequencing, setpoint adjustment and window slot bookkeeping.
// Depends on tma_pkg.
module tma_ctrl #(
  parameter int unsigned WINDOW_LEN = 10,
  localparam int unsigned SLOT_W = $clog2(WINDOW_LEN)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  tma_pkg::in_item_t          item,
  input  tma_pkg::cfg_t              cfg,
  input  logic                       sp_load,
  input  logic [tma_pkg::TEMP_W-1:0] sp_load_value,
  output tma_pkg::ctl_t              ctl,
  output tma_pkg::samp_t             samp,
  output logic [SLOT_W-1:0]          slot
);
  import tma_pkg::*;

  localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);
  localparam logic [TEMP_W-1:0] STEP = 9'd5;
  localparam logic [TEMP_W-1:0] TEMP_MAX = 9'd511;

  localparam logic [MODE_W-1:0] MODE_CODE_OFF = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_REG = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_SET = 2'd2;

  typedef enum logic [2:0] {
    MODE_OFF = 3'b001,
    MODE_REG = 3'b010,
    MODE_SET = 3'b100
  } mode_t;

  mode_t             mode_r, mode_nxt;
  logic [TEMP_W-1:0] setpoint_r, setpoint_nxt;
  logic [TEMP_W-1:0] latest_r, latest_nxt;
  logic              primed_r, primed_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [FILL_W-1:0] filled_r, filled_nxt;

  logic              up_ok, dn_ok, reg_pass, take;
  logic [TEMP_W-1:0] sp_up, sp_dn, temp;

  // Setpoint step candidates, saturating at both ends of the range.
  always_comb begin
    temp  = item.adc_sample[ADC_W-1:1];
    up_ok = item.btn_up && (setpoint_r < cfg.highest_setpoint);
    dn_ok = item.btn_down && (setpoint_r > cfg.lowest_setpoint);
    sp_up = (setpoint_r > TEMP_MAX - STEP) ? TEMP_MAX : setpoint_r + STEP;
    sp_dn = (setpoint_r < STEP) ? '0 : setpoint_r - STEP;
    reg_pass = (mode_r != MODE_SET) || item.setting_timeout;
    take = item.sample_valid;
  end

  // Next state and the part of the result that does not need the average.
  always_comb begin
    mode_nxt     = mode_r;
    setpoint_nxt = setpoint_r;
    latest_nxt   = latest_r;
    primed_nxt   = primed_r;
    slot_nxt     = slot_r;
    filled_nxt   = filled_r;
    ctl          = '0;
    samp         = '0;
    samp.temp    = temp;
    ctl.blink    = item.blink_phase;
    ctl.setpoint = setpoint_r;
    ctl.res.mode = MODE_CODE_OFF;
    ctl.res.setpoint_save = setpoint_r;
    if (!item.power_enable) begin
      mode_nxt = MODE_OFF;
    end else if (reg_pass) begin
      // Regulating pass: update the window with the new sample, if any.
      samp.take  = take;
      samp.prime = take && !primed_r;
      samp.stale = take && primed_r && (FILL_W'(slot_r) >= filled_r);
      if (take) begin
        latest_nxt = temp;
        primed_nxt = 1'b1;
        slot_nxt   = (slot_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_r + 1'b1;
        if (!primed_r) begin
          filled_nxt = FILL_W'(1);
        end else if (filled_r != FILL_W'(WINDOW_LEN)) begin
          filled_nxt = filled_r + 1'b1;
        end
      end
      ctl.decide = primed_r || take;
      ctl.res.display_value = latest_nxt;
      if (item.btn_up || item.btn_down) begin
        mode_nxt = MODE_SET;
        ctl.res.mode = MODE_CODE_SET;
        ctl.res.display_on = 1'b0;
      end else begin
        mode_nxt = MODE_REG;
        ctl.res.mode = MODE_CODE_REG;
        ctl.res.display_on = 1'b1;
      end
    end else begin
      // Setting pass: up wins over down when both are pressed and up can still move.
      mode_nxt = MODE_SET;
      ctl.res.mode = MODE_CODE_SET;
      if (up_ok) begin
        setpoint_nxt = sp_up;
      end else if (dn_ok) begin
        setpoint_nxt = sp_dn;
      end
      ctl.res.display_on    = up_ok || dn_ok || item.blink_phase;
      ctl.res.display_value = setpoint_nxt;
      ctl.res.setpoint_save = setpoint_nxt;
    end
    slot = slot_r;
  end

  // Control state; a setpoint register write reloads the setpoint.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_OFF;
      setpoint_r <= START_SETPOINT_RST;
      latest_r   <= '0;
      primed_r   <= 1'b0;
      slot_r     <= '0;
      filled_r   <= '0;
    end else begin
      if (sp_load) begin
        setpoint_r <= sp_load_value;
      end else if (accept) begin
        setpoint_r <= setpoint_nxt;
      end
      if (accept) begin
        mode_r   <= mode_nxt;
        latest_r <= latest_nxt;
        primed_r <= primed_nxt;
        slot_r   <= slot_nxt;
        filled_r <= filled_nxt;
      end
    end
  end

`ifndef SYNTH
  // The fill count never runs past the window length.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= FILL_W'(WINDOW_LEN))
    else $error("window fill count out of range");

  // Before the first sample nothing has been assigned in the window.
  a_unprimed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !primed_r |-> (filled_r == '0) && (slot_r == '0))
    else $error("window bookkeeping moved before priming");
`endif

endmodule

[design/tma_window.sv]
`timescale 1ns / 1ps
// Sample window memory with read-modify-write of the running sum.
// Depends on tma_pkg.
module tma_window #(
  parameter int unsigned WINDOW_LEN = 10,
  localparam int unsigned SLOT_W = $clog2(WINDOW_LEN)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [SLOT_W-1:0]         rd_slot,
  input  logic                      wr_en,
  input  logic [SLOT_W-1:0]         wr_slot,
  input  tma_pkg::samp_t            samp,
  output logic [tma_pkg::SUM_W-1:0] sum
);
  import tma_pkg::*;

  logic [TEMP_W-1:0] mem [WINDOW_LEN];
  logic [TEMP_W-1:0] rdata_r;
  logic [TEMP_W-1:0] prime_temp_r;
  logic [TEMP_W-1:0] old_temp;
  logic [SUM_W-1:0]  sum_r, sum_nxt;

  // Oldest entry is read when the item is accepted and written one stage later.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_slot];
    end
    if (wr_en && samp.take) begin
      mem[wr_slot] <= samp.temp;
    end
  end

  // Slots not yet reached after priming still hold the first temperature.
  always_ff @(posedge clk) begin
    if (wr_en && samp.prime) begin
      prime_temp_r <= samp.temp;
    end
  end

  // Running sum: the first sample stands for the whole window.
  always_comb begin
    old_temp = samp.stale ? prime_temp_r : rdata_r;
    if (samp.prime) begin
      sum_nxt = SUM_W'(SUM_W'(samp.temp) * SUM_W'(WINDOW_LEN));
    end else begin
      sum_nxt = sum_r - SUM_W'(old_temp) + SUM_W'(samp.temp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (wr_en && samp.take) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

`ifndef SYNTH
  // A read and a write-back in the same cycle never hit the same slot.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && wr_en && samp.take |-> rd_slot != wr_slot)
    else $error("window read and write collide on one slot");
`endif

endmodule

[design/tma_decide.sv]
`timescale 1ns / 1ps
// Average by reciprocal multiply, then the dead-band heat/cool decision.
// Depends on tma_pkg.
module tma_decide #(
  parameter int unsigned WINDOW_LEN = 10
) (
  input  logic                         clk,
  input  logic                         ld_avg,
  input  logic                         ld_out,
  input  logic [tma_pkg::SUM_W-1:0]    sum,
  input  tma_pkg::ctl_t                ctl,
  input  logic [tma_pkg::MARGIN_W-1:0] band_margin,
  output tma_pkg::out_item_t           out_data
);
  import tma_pkg::*;

  // Exact floor division of any SUM_W-bit value by the window length.
  localparam int unsigned SHIFT   = SUM_W + $clog2(WINDOW_LEN);
  localparam int unsigned RECIP_W = SUM_W + 2;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

  logic [PROD_W-1:0] prod;
  logic [TEMP_W-1:0] avg_r;
  ctl_t              ctl_r;
  logic [TEMP_W:0]   sp_hi, avg_hi;
  logic              cool, heat;
  out_item_t         res;
  out_item_t         out_r;

  assign prod = PROD_W'(sum) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (ld_avg) begin
      avg_r <= prod[SHIFT +: TEMP_W];
      ctl_r <= ctl;
    end
  end

  // Bang-bang decision around the setpoint with the dead band.
  always_comb begin
    sp_hi  = {1'b0, ctl_r.setpoint} + (TEMP_W + 1)'(band_margin);
    avg_hi = {1'b0, avg_r} + (TEMP_W + 1)'(band_margin);
    cool   = ({1'b0, avg_r} >= sp_hi) && (avg_r > ctl_r.setpoint);
    heat   = (avg_hi <= {1'b0, ctl_r.setpoint}) && (avg_r < ctl_r.setpoint);
    res    = ctl_r.res;
    if (ctl_r.decide) begin
      if (cool) begin
        res.cooler_on = 1'b1;
        res.led_on    = 1'b1;
      end else if (heat) begin
        res.heater_on = 1'b1;
        res.led_on    = ctl_r.blink;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_r <= res;
    end
  end

  assign out_data = out_r;

endmodule

[sim/thermostat_moving_average_control_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the moving-average thermostat controller.
// Depends on tma_pkg and thermostat_moving_average_control; needs no files.
module thermostat_moving_average_control_tb;
  import tma_pkg::*;

  localparam int unsigned WIN_LEN = 10;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STALL_LIMIT = 5000;

  // Mode codes as they appear on the result channel.
  localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REG = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SET = 2'd2;

  // Register indexes; each register sits at byte address 4 * index.
  localparam int unsigned REG_BAND_MARGIN      = 0;
  localparam int unsigned REG_LOWEST_SETPOINT  = 1;
  localparam int unsigned REG_HIGHEST_SETPOINT = 2;
  localparam int unsigned REG_START_SETPOINT   = 3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [CFG_AW-1:0]  paddr = '0;
  logic [CFG_DW-1:0]  pwdata = '0;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  // Local copy of the controller state and registers.
  logic [MODE_W-1:0]  th_mode;
  int unsigned        th_window [WIN_LEN];
  int unsigned        th_sum;
  int unsigned        th_slot;
  logic               th_primed;
  logic [TEMP_W-1:0]  th_latest;
  logic [TEMP_W-1:0]  th_setpoint;
  logic [MARGIN_W-1:0] cfg_margin;
  logic [TEMP_W-1:0]  cfg_lowest;
  logic [TEMP_W-1:0]  cfg_highest;
  logic [TEMP_W-1:0]  cfg_start;

  out_item_t          pending_drive [$];
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  int unsigned        items_sent = 0;
  int unsigned        results_seen = 0;
  int unsigned        mismatch_count = 0;
  int unsigned        quiet_cycles = 0;

  thermostat_moving_average_control #(
    .WINDOW_LEN(WIN_LEN)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // Predicts the controller outputs for one item and advances the local state.
  function automatic out_item_t step_thermostat(in_item_t it);
    out_item_t         r;
    logic [TEMP_W-1:0] t;
    int unsigned       avg;
    logic              moved;
    r = '0;
    if (!it.power_enable) begin
      th_mode = MODE_OFF;
    end else begin
      if (th_mode != MODE_SET || it.setting_timeout) th_mode = MODE_REG;
      if (th_mode == MODE_REG) begin
        if (it.sample_valid) begin
          t = it.adc_sample[ADC_W-1:1];
          if (!th_primed) begin
            // The first sample fills the whole window.
            for (int i = 0; i < WIN_LEN; i++) th_window[i] = t;
            th_sum = t * WIN_LEN;
            th_slot = 1 % WIN_LEN;
            th_primed = 1'b1;
          end else begin
            th_sum = th_sum - th_window[th_slot] + t;
            th_window[th_slot] = t;
            th_slot = (th_slot + 1) % WIN_LEN;
          end
          th_sum = th_sum & 32'h1FFF;
          th_latest = t;
        end
        // Bang-bang decision around the dead band.
        if (th_primed) begin
          avg = th_sum / WIN_LEN;
          if (avg >= th_setpoint + cfg_margin && avg > th_setpoint) begin
            r.cooler_on = 1'b1;
            r.led_on = 1'b1;
          end else if (avg + cfg_margin <= th_setpoint && avg < th_setpoint) begin
            r.heater_on = 1'b1;
            r.led_on = it.blink_phase;
          end
        end
        r.display_on = 1'b1;
        r.display_value = th_latest;
        if (it.btn_up || it.btn_down) begin
          r.display_on = 1'b0;
          th_mode = MODE_SET;
        end
      end else begin
        // Setting mode: up has priority, each press moves by 5 and saturates.
        moved = 1'b0;
        if (it.btn_up && th_setpoint < cfg_highest) begin
          th_setpoint = (th_setpoint > 9'd506) ? 9'd511 : th_setpoint + 9'd5;
          moved = 1'b1;
        end else if (it.btn_down && th_setpoint > cfg_lowest) begin
          th_setpoint = (th_setpoint < 9'd5) ? 9'd0 : th_setpoint - 9'd5;
          moved = 1'b1;
        end
        r.display_on = moved || it.blink_phase;
        r.display_value = th_setpoint;
      end
    end
    r.mode = th_mode;
    r.setpoint_save = th_setpoint;
    return r;
  endfunction

  function automatic in_item_t make_item(logic pwr, logic sv, logic [ADC_W-1:0] adc,
                                         logic up, logic dn, logic blink, logic tmo);
    in_item_t it;
    it.power_enable = pwr;
    it.sample_valid = sv;
    it.adc_sample = adc;
    it.btn_up = up;
    it.btn_down = dn;
    it.blink_phase = blink;
    it.setting_timeout = tmo;
    return it;
  endfunction

  // Mostly powered-on traffic with samples near twice the setpoint so the
  // average wanders across the dead band; some full-range noise as well.
  function automatic in_item_t random_item();
    in_item_t it;
    int       v;
    it.power_enable = ($urandom_range(99) < 94);
    it.sample_valid = ($urandom_range(99) < 70);
    if ($urandom_range(99) < 60) begin
      v = 2 * int'(th_setpoint) + int'($urandom_range(80)) - 40;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      it.adc_sample = v[ADC_W-1:0];
    end else begin
      it.adc_sample = ADC_W'($urandom_range(1023));
    end
    it.btn_up = ($urandom_range(99) < 12);
    it.btn_down = ($urandom_range(99) < 12);
    it.blink_phase = 1'($urandom_range(1));
    it.setting_timeout = ($urandom_range(99) < 25);
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_drive(out_item_t got, out_item_t want);
    if (got.mode != want.mode)
      report_mismatch($sformatf("mode got %0d expected %0d", got.mode, want.mode));
    if (got.heater_on != want.heater_on)
      report_mismatch($sformatf("heater_on got %0b expected %0b", got.heater_on,
                                want.heater_on));
    if (got.cooler_on != want.cooler_on)
      report_mismatch($sformatf("cooler_on got %0b expected %0b", got.cooler_on,
                                want.cooler_on));
    if (got.led_on != want.led_on)
      report_mismatch($sformatf("led_on got %0b expected %0b", got.led_on, want.led_on));
    if (got.display_on != want.display_on)
      report_mismatch($sformatf("display_on got %0b expected %0b", got.display_on,
                                want.display_on));
    if (got.display_value != want.display_value)
      report_mismatch($sformatf("display_value got %0d expected %0d", got.display_value,
                                want.display_value));
    if (got.setpoint_save != want.setpoint_save)
      report_mismatch($sformatf("setpoint_save got %0d expected %0d", got.setpoint_save,
                                want.setpoint_save));
  endtask

  // Sends one item, with random idle cycles ahead of it.
  task automatic send_item(in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_drive.push_back(step_thermostat(it));
    items_sent++;
  endtask

  // Holds the input off until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; only done with the block idle.
  task automatic write_reg(int unsigned idx, int unsigned value);
    drain_results();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = CFG_AW'(idx * 4);
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_BAND_MARGIN:      cfg_margin = value[MARGIN_W-1:0];
      REG_LOWEST_SETPOINT:  cfg_lowest = value[TEMP_W-1:0];
      REG_HIGHEST_SETPOINT: cfg_highest = value[TEMP_W-1:0];
      REG_START_SETPOINT: begin
        cfg_start = value[TEMP_W-1:0];
        th_setpoint = cfg_start;
      end
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_config(int unsigned margin, int unsigned lowest, int unsigned highest,
                            int unsigned start);
    write_reg(REG_BAND_MARGIN, margin);
    write_reg(REG_LOWEST_SETPOINT, lowest);
    write_reg(REG_HIGHEST_SETPOINT, highest);
    write_reg(REG_START_SETPOINT, start);
  endtask

  // Power off, power on without a sample, first sample priming, odd codes.
  task automatic test_power_and_prime();
    send_item(make_item(1'b0, 1'b1, 10'd1023, 1'b1, 1'b1, 1'b1, 1'b1));
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(1'b1, 1'b1, 10'd121, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(1'b1, 1'b1, 10'd1023, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(1'b1, 1'b1, 10'd0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(1'b1, 1'b1, 10'd1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(1'b1, 1'b1, 10'd1022, 1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  // Entering and leaving setting mode, limits, both buttons, blinking display.
  task automatic test_setting_mode();
    set_config(5, 35, 75, 60);
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b1, 1'b0, 1'b1, 1'b0));
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b1, 1'b1, 1'b0, 1'b0));
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b1, 1'b0, 1'b1, 1'b0));
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b1, 1'b1, 1'b0, 1'b0));
    // A sample in setting mode must leave the window alone.
    send_item(make_item(1'b1, 1'b1, 10'd1023, 1'b0, 1'b1, 1'b0, 1'b0));
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(1'b1, 1'b1, 10'd200, 1'b0, 1'b0, 1'b1, 1'b1));
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_item(make_item(1'b0, 1'b0, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b0, 1'b0, 1'b1, 1'b0));
  endtask

  // Setpoint saturation at both ends of the 9-bit range.
  task automatic test_setpoint_bounds();
    set_config(5, 0, 511, 3);
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b0, 1'b1, 1'b0, 1'b1));
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b0, 1'b1, 1'b1, 1'b0));
    write_reg(REG_START_SETPOINT, 508);
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b1, 1'b0, 1'b0, 1'b1));
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b1, 1'b0, 1'b1, 1'b0));
  endtask

  // Dead band edges: zero margin at the average, heating with blink, widest margin.
  task automatic test_dead_band();
    int unsigned avg;
    drain_results();
    avg = th_sum / WIN_LEN;
    write_reg(REG_BAND_MARGIN, 0);
    write_reg(REG_START_SETPOINT, avg);
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b0, 1'b0, 1'b1, 1'b1));
    write_reg(REG_START_SETPOINT, (avg < 511) ? avg + 1 : avg);
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b0, 1'b0, 1'b1, 1'b1));
    write_reg(REG_START_SETPOINT, (avg > 0) ? avg - 1 : avg);
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b0, 1'b0, 1'b0, 1'b1));
    write_reg(REG_BAND_MARGIN, 63);
    write_reg(REG_START_SETPOINT, 511);
    send_item(make_item(1'b1, 1'b0, 10'd0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(make_item(1'b1, 1'b1, 10'd0, 1'b0, 1'b0, 1'b1, 1'b0));
  endtask

  task automatic run_random(int unsigned count, int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  // Random traffic under several register settings and three stall profiles.
  task automatic test_random();
    set_config(5, 35, 75, 60);
    run_random(120, 26, 85);
    set_config(0, 0, 511, 0);
    run_random(120, 26, 85);
    set_config(63, 200, 300, 250);
    run_random(120, 85, 26);
    set_config($urandom_range(63), $urandom_range(511), $urandom_range(511),
               $urandom_range(511));
    run_random(120, 85, 26);
    set_config(1, 511, 0, 511);
    run_random(110, 0, 0);
    set_config($urandom_range(63), $urandom_range(511), $urandom_range(511),
               $urandom_range(511));
    run_random(110, 0, 0);
  endtask

  // Receiver stall, changed only at the falling edge.
  always @(negedge clk) begin
    out_stall = rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  // Result checker against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_drive.size() == 0) begin
        report_mismatch("result with no item waiting for it");
      end else begin
        compare_drive(out_data, pending_drive.pop_front());
      end
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    th_mode = MODE_OFF;
    for (int i = 0; i < WIN_LEN; i++) th_window[i] = 0;
    th_sum = 0;
    th_slot = 0;
    th_primed = 1'b0;
    th_latest = '0;
    cfg_margin = BAND_MARGIN_RST;
    cfg_lowest = LOWEST_SETPOINT_RST;
    cfg_highest = HIGHEST_SETPOINT_RST;
    cfg_start = START_SETPOINT_RST;
    th_setpoint = START_SETPOINT_RST;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 26;
    recv_idle_pct = 85;
    test_power_and_prime();
    test_setting_mode();
    test_setpoint_bounds();
    test_dead_band();
    test_random();

    drain_results();
    if (pending_drive.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_drive.size()));
    $display("Summary: %0d items sent (power, priming, setting, bounds, dead band, random)",
             items_sent);
    $display("Summary: %0d results checked, %0d mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
